@@ design/hqxdec_pkg.sv @@
// Shared types, codes and constants for the hqx character decoder.
`timescale 1ns / 1ps
`default_nettype none

package hqxdec_pkg;

  localparam logic [7:0]  RleMark = 8'h90;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Command codes carried in the input transaction.
  typedef enum logic [1:0] {
    CmdChar     = 2'd0,
    CmdClearCrc = 2'd1,
    CmdRestart  = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  // Error codes reported in a result.
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrIllegal = 2'd1;
  localparam logic [1:0] ErrRepeat  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [7:0]  repeat_count;
    logic [15:0] crc_check;
    logic [1:0]  error_code;
  } out_item_t;

  // Character classification from the symbol mapper.
  typedef struct packed {
    logic       is_space;
    logic       illegal;
    logic [5:0] sym;
  } sym_info_t;

endpackage

`default_nettype wire

@@ design/hqxdec_sym_map.sv @@
// Maps one hqx character to its 6-bit symbol, flags whitespace and illegal codes.
`timescale 1ns / 1ps
`default_nettype none

module hqxdec_sym_map
  import hqxdec_pkg::*;
(
  input  logic [7:0] char_i,
  output sym_info_t  info_o
);

  logic [7:0] idx;
  logic       hit;

  // Alphabet is a set of contiguous ASCII runs; index = char - run start + run base.
  always_comb begin
    idx = 8'd0;
    hit = 1'b1;
    priority if (char_i >= 8'h21 && char_i <= 8'h2D) begin
      idx = char_i - 8'h21;
    end else if (char_i >= 8'h30 && char_i <= 8'h36) begin
      idx = char_i - 8'h30 + 8'd13;
    end else if (char_i >= 8'h38 && char_i <= 8'h39) begin
      idx = char_i - 8'h38 + 8'd20;
    end else if (char_i >= 8'h40 && char_i <= 8'h4E) begin
      idx = char_i - 8'h40 + 8'd22;
    end else if (char_i >= 8'h50 && char_i <= 8'h56) begin
      idx = char_i - 8'h50 + 8'd37;
    end else if (char_i >= 8'h58 && char_i <= 8'h5B) begin
      idx = char_i - 8'h58 + 8'd44;
    end else if (char_i >= 8'h60 && char_i <= 8'h66) begin
      idx = char_i - 8'h60 + 8'd48;
    end else if (char_i >= 8'h68 && char_i <= 8'h6D) begin
      idx = char_i - 8'h68 + 8'd55;
    end else if (char_i >= 8'h70 && char_i <= 8'h72) begin
      idx = char_i - 8'h70 + 8'd61;
    end else begin
      hit = 1'b0;
    end
  end

  assign info_o.is_space = (char_i == 8'h0D) || (char_i == 8'h0A) ||
                           (char_i == 8'h09) || (char_i == 8'h20);
  assign info_o.illegal  = !hit && !info_o.is_space;
  assign info_o.sym      = idx[5:0];

endmodule

`default_nettype wire

@@ design/hqxdec_crc_unit.sv @@
// Shared CRC-16 byte feed unit (augmented form, poly 0x1021), one byte per use.
`timescale 1ns / 1ps
`default_nettype none

module hqxdec_crc_unit
  import hqxdec_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [15:0] t;

  always_comb begin
    t = {crc_i[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (t[15]) begin
        t = {t[14:0], 1'b0} ^ CrcPoly;
      end else begin
        t = {t[14:0], 1'b0};
      end
    end
    crc_o = {crc_i[7:0], byte_i} ^ t;
  end

endmodule

`default_nettype wire

@@ design/hqx_char_decoder_rle_crc_core.sv @@
// Top level: hqx body decoder with run-length expansion and CRC-16 sequencer.
`timescale 1ns / 1ps
`default_nettype none

// BinHex 4.0 body decoder. One transaction in carries a command and a character;
// cmd CmdChar decodes a body character (CR, LF, tab and space are skipped),
// CmdClearCrc zeroes the section CRC, CmdRestart resets the decoder state (not
// the output register). Four alphabet symbols regroup into three bytes, which
// then pass run-length expansion (0x90 marker, next byte is a count). A result
// carries the byte, how many copies it stands for, the CRC finalized with two
// zero bytes and a sticky error code. A transaction that gives no result is
// taken and the next one can follow right away. A transaction that gives a
// result holds in_ready_o low after it is taken while the block runs StFeed
// (not for an error), StFin1, StFin2 and StEmit: one shared byte-wide CRC unit
// does every feed, one byte a cycle, for the n bytes fed into the CRC (0 for an
// error, 1 for a plain byte, count - 1 for a run, so up to 254), then the two
// finalizing zero-byte feeds, and StEmit loads the output register. The output
// register holds a result until it is taken while new input is accepted; a
// second result waits in the load cycle, with in_ready_o low, until it is free.
module hqx_char_decoder_rle_crc_core
  import hqxdec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle,
    StFeed,
    StFin1,
    StFin2,
    StEmit
  } state_e;

  state_e      state_q;

  // Decoder state
  logic [1:0]  phase_q;
  logic [5:0]  held_q;
  logic        marker_q;
  logic [7:0]  prev_q;
  logic        have_q;
  logic [15:0] crc_q;
  logic [1:0]  err_q;

  // Work registers for the result being built
  logic [7:0]  res_byte_q;
  logic [7:0]  res_cnt_q;
  logic [1:0]  res_err_q;
  logic [7:0]  feed_byte_q;
  logic [7:0]  feed_cnt_q;
  logic [15:0] fin_q;

  // Output register
  logic        out_valid_q;
  out_item_t   out_q;

  sym_info_t   sym;
  logic        in_fire;
  logic [7:0]  byte_asm;
  logic [5:0]  held_nxt;
  logic [15:0] unit_crc;
  logic [7:0]  unit_byte;
  logic [15:0] unit_out;

  hqxdec_sym_map u_sym_map (
    .char_i (in_data_i.char_in),
    .info_o (sym)
  );

  hqxdec_crc_unit u_crc_unit (
    .crc_i  (unit_crc),
    .byte_i (unit_byte),
    .crc_o  (unit_out)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Regroup: each symbol after the first of a group completes a byte.
  always_comb begin
    unique case (phase_q)
      2'd1: begin
        byte_asm = {held_q, sym.sym[5:4]};
        held_nxt = {2'b00, sym.sym[3:0]};
      end
      2'd2: begin
        byte_asm = {held_q[3:0], sym.sym[5:2]};
        held_nxt = {4'b0000, sym.sym[1:0]};
      end
      2'd3: begin
        byte_asm = {held_q[1:0], sym.sym};
        held_nxt = 6'd0;
      end
      default: begin
        byte_asm = 8'd0;
        held_nxt = sym.sym;
      end
    endcase
  end

  // Shared CRC unit operand select
  always_comb begin
    unique case (state_q)
      StFeed: begin
        unit_crc  = crc_q;
        unit_byte = feed_byte_q;
      end
      StFin2: begin
        unit_crc  = fin_q;
        unit_byte = 8'd0;
      end
      default: begin
        unit_crc  = crc_q;
        unit_byte = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= 2'd0;
      held_q      <= 6'd0;
      marker_q    <= 1'b0;
      prev_q      <= 8'd0;
      have_q      <= 1'b0;
      crc_q       <= 16'd0;
      err_q       <= ErrNone;
      res_byte_q  <= 8'd0;
      res_cnt_q   <= 8'd0;
      res_err_q   <= ErrNone;
      feed_byte_q <= 8'd0;
      feed_cnt_q  <= 8'd0;
      fin_q       <= 16'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // the load cycle refills the register itself when it is freed
      if (out_valid_q && out_ready_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            unique case (cmd_e'(in_data_i.cmd))
              CmdChar: begin
                // sticky error: body characters are ignored until restart
                if (err_q == ErrNone && !sym.is_space) begin
                  if (sym.illegal) begin
                    err_q      <= ErrIllegal;
                    res_byte_q <= 8'd0;
                    res_cnt_q  <= 8'd0;
                    res_err_q  <= ErrIllegal;
                    state_q    <= StFin1;
                  end else if (phase_q == 2'd0) begin
                    held_q  <= held_nxt;
                    phase_q <= 2'd1;
                  end else begin
                    held_q  <= held_nxt;
                    phase_q <= phase_q + 2'd1;
                    if (marker_q) begin
                      marker_q <= 1'b0;
                      if (byte_asm == 8'd0) begin
                        // escaped literal marker byte
                        prev_q      <= RleMark;
                        have_q      <= 1'b1;
                        res_byte_q  <= RleMark;
                        res_cnt_q   <= 8'd1;
                        res_err_q   <= ErrNone;
                        feed_byte_q <= RleMark;
                        feed_cnt_q  <= 8'd1;
                        state_q     <= StFeed;
                      end else if (!have_q) begin
                        err_q      <= ErrRepeat;
                        res_byte_q <= 8'd0;
                        res_cnt_q  <= 8'd0;
                        res_err_q  <= ErrRepeat;
                        state_q    <= StFin1;
                      end else if (byte_asm != 8'd1) begin
                        // run: count - 1 extra copies of the last byte
                        res_byte_q  <= prev_q;
                        res_cnt_q   <= byte_asm - 8'd1;
                        res_err_q   <= ErrNone;
                        feed_byte_q <= prev_q;
                        feed_cnt_q  <= byte_asm - 8'd1;
                        state_q     <= StFeed;
                      end
                    end else if (byte_asm == RleMark) begin
                      marker_q <= 1'b1;
                    end else begin
                      prev_q      <= byte_asm;
                      have_q      <= 1'b1;
                      res_byte_q  <= byte_asm;
                      res_cnt_q   <= 8'd1;
                      res_err_q   <= ErrNone;
                      feed_byte_q <= byte_asm;
                      feed_cnt_q  <= 8'd1;
                      state_q     <= StFeed;
                    end
                  end
                end
              end
              CmdClearCrc: begin
                crc_q <= 16'd0;
              end
              CmdRestart: begin
                phase_q  <= 2'd0;
                held_q   <= 6'd0;
                marker_q <= 1'b0;
                prev_q   <= 8'd0;
                have_q   <= 1'b0;
                crc_q    <= 16'd0;
                err_q    <= ErrNone;
              end
              CmdNone: begin
              end
            endcase
          end
        end
        StFeed: begin
          crc_q      <= unit_out;
          feed_cnt_q <= feed_cnt_q - 8'd1;
          if (feed_cnt_q == 8'd1) begin
            state_q <= StFin1;
          end
        end
        StFin1: begin
          fin_q   <= unit_out;
          state_q <= StFin2;
        end
        StFin2: begin
          fin_q   <= unit_out;
          state_q <= StEmit;
        end
        StEmit: begin
          // wait until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q           <= 1'b1;
            out_q.out_byte        <= res_byte_q;
            out_q.repeat_count    <= res_cnt_q;
            out_q.crc_check       <= fin_q;
            out_q.error_code      <= res_err_q;
            state_q               <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/hqxdec_checker.sv @@
// Port-level assertion checker for the hqx decoder core, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module hqxdec_checker
  import hqxdec_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Error results carry no byte and no copies.
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ErrNone |->
      out_data_o.out_byte == 8'd0 && out_data_o.repeat_count == 8'd0)
    else $error("error result with data");

  // Data results stand for at least one copy.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code == ErrNone |-> out_data_o.repeat_count != 8'd0)
    else $error("data result with zero count");

  // Control commands never make the block busy.
  a_cmd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd != CmdChar |=> in_ready_o)
    else $error("control command stalled input");

endmodule

bind hqx_char_decoder_rle_crc_core hqxdec_checker u_hqxdec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
